@@ rtl/sfc_pkg.sv @@
// Package for the SysEx frame commit FIFO: constants, request codes and the
// memory control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

  localparam int STORE_DEPTH_DEF = 256;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;

  // request codes on req_type
  localparam logic REQ_RX  = 1'b0;
  localparam logic REQ_POP = 1'b1;

  // strobes from the controller to the ring store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ rtl/sfc_if.sv @@
// Valid/ready channel interfaces for the SysEx frame commit FIFO.
// Depends on nothing; payload widths are fixed.
`timescale 1ns / 1ps
`default_nettype none

interface sfc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic       framing_error;
  logic       overrun;

  modport source (output valid, req_type, rx_byte, framing_error, overrun, input ready);
  modport sink   (input valid, req_type, rx_byte, framing_error, overrun, output ready);
endinterface

interface sfc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] pop_data;
  logic       pop_valid;
  logic       error_flag;

  modport source (output valid, pop_data, pop_valid, error_flag, input ready);
  modport sink   (input valid, pop_data, pop_valid, error_flag, output ready);
endinterface

`default_nettype wire

@@ rtl/sfc_store.sv @@
// Ring store: one write port, one read port, registered read data.
// Depends on sfc_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module sfc_store #(
  parameter int STORE_DEPTH = sfc_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  wire logic             clk,
  input  wire sfc_pkg::mem_ctl_t ctl,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [7:0]       wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [7:0]       rd_data
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read, so a stalled result stays put
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sfc_ctrl.sv @@
// Pointer and framing control plus the result register.
// Depends on sfc_pkg for constants, request codes and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module sfc_ctrl #(
  parameter int STORE_DEPTH = sfc_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire logic              out_take,
  input  wire logic              req_type,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              framing_error,
  input  wire logic              overrun,
  output sfc_pkg::mem_ctl_t      ctl,
  output logic      [AW-1:0]     wr_addr,
  output logic      [7:0]        wr_data,
  output logic      [AW-1:0]     rd_addr,
  output logic                   res_valid,
  output logic                   res_pop_valid,
  output logic                   res_err
);

  localparam logic [AW-1:0] PTR_LAST = AW'(STORE_DEPTH - 1);

  logic [AW-1:0] write_ptr, write_ptr_next;
  logic [AW-1:0] commit_ptr, commit_ptr_next;
  logic [AW-1:0] read_ptr, read_ptr_next;
  logic          in_frame, in_frame_next;
  logic          error_latch, error_latch_next;
  logic          pop_hit;
  logic [AW-1:0] write_inc, read_inc;

  assign write_inc = (write_ptr == PTR_LAST) ? '0 : write_ptr + 1'b1;
  assign read_inc  = (read_ptr == PTR_LAST) ? '0 : read_ptr + 1'b1;

  assign wr_addr = write_ptr;
  assign wr_data = rx_byte;
  assign rd_addr = read_ptr;

  always_comb begin
    write_ptr_next   = write_ptr;
    commit_ptr_next  = commit_ptr;
    read_ptr_next    = read_ptr;
    in_frame_next    = in_frame;
    error_latch_next = error_latch;
    ctl              = '0;
    pop_hit          = 1'b0;
    if (in_fire) begin
      if (req_type == sfc_pkg::REQ_POP) begin
        if (read_ptr != commit_ptr) begin
          pop_hit       = 1'b1;
          ctl.rd_en     = 1'b1;
          read_ptr_next = read_inc;
        end
      end else if (overrun) begin
        error_latch_next = 1'b1;
      end else if (framing_error) begin
        error_latch_next = 1'b1;
        in_frame_next    = 1'b0;
        write_ptr_next   = commit_ptr;
      end else if (rx_byte == sfc_pkg::SYSEX_START) begin
        in_frame_next  = 1'b1;
        write_ptr_next = commit_ptr;
      end else if (in_frame) begin
        ctl.wr_en      = 1'b1;
        write_ptr_next = write_inc;
        if (rx_byte == sfc_pkg::SYSEX_END) begin
          in_frame_next   = 1'b0;
          commit_ptr_next = write_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr   <= '0;
      commit_ptr  <= '0;
      read_ptr    <= '0;
      in_frame    <= 1'b0;
      error_latch <= 1'b0;
    end else begin
      write_ptr   <= write_ptr_next;
      commit_ptr  <= commit_ptr_next;
      read_ptr    <= read_ptr_next;
      in_frame    <= in_frame_next;
      error_latch <= error_latch_next;
    end
  end

  // result register; loads with each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_fire) begin
      res_valid <= 1'b1;
    end else if (out_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_pop_valid <= pop_hit;
      res_err       <= error_latch_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sysex_frame_commit_fifo.sv @@
// SysEx frame commit FIFO: framed receive ring buffer with commit on end byte.
// A result is presented in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the single result
// register is the only buffering, so a stalled result holds off the next item.
// Reset (rst, synchronous): pointers, frame state and error flag clear; store not cleared.
// Depends on sfc_pkg, sfc_if, sfc_store and sfc_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module sysex_frame_commit_fifo #(
  parameter int STORE_DEPTH = sfc_pkg::STORE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  sfc_req_if.sink   req,
  sfc_rsp_if.source rsp
);

  localparam int AW = $clog2(STORE_DEPTH);

  sfc_pkg::mem_ctl_t ctl;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        wr_data;
  logic [7:0]        rd_data;
  logic              res_valid;
  logic              res_pop_valid;
  logic              res_err;
  logic              in_fire;
  logic              out_take;

  // Accept when the result register is empty or is being drained this cycle.
  assign req.ready = !res_valid || rsp.ready;
  assign in_fire   = req.valid && req.ready;
  assign out_take  = res_valid && rsp.ready;

  // Control: pointers, framing and the result register. Writes to the store
  // happen at the accept edge; a pop's read lands in the store's output
  // register at the same edge, so a pop right after a write sees the new byte.
  sfc_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .out_take      (out_take),
    .req_type      (req.req_type),
    .rx_byte       (req.rx_byte),
    .framing_error (req.framing_error),
    .overrun       (req.overrun),
    .ctl           (ctl),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr       (rd_addr),
    .res_valid     (res_valid),
    .res_pop_valid (res_pop_valid),
    .res_err       (res_err)
  );

  // Ring store; read data holds while the result waits.
  sfc_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Data reads as zero unless the pop found a committed byte.
  assign rsp.valid      = res_valid;
  assign rsp.pop_valid  = res_pop_valid;
  assign rsp.pop_data   = res_pop_valid ? rd_data : 8'h00;
  assign rsp.error_flag = res_err;

endmodule

`default_nettype wire
